// ----- hw/rtl/gga_pkg.sv -----
// ----------------------------------------------------------------------------
// gga_pkg
// Shared types, character codes and digit helpers of the GGA sentence parser.
// ----------------------------------------------------------------------------
package gga_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA,
		PH_SUM
	} phase_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;

	localparam logic [7:0] HDR_LEN    = 8'd5;
	localparam logic [7:0] SUM_DIGITS = 8'd2;
	localparam logic [7:0] SAT_MAX    = 8'd255;

	localparam logic [18:0] SEC_PER_HOUR = 19'd3600;
	localparam logic [18:0] SEC_PER_MIN  = 19'd60;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [7:0]  char_in;
		logic [31:0] now_ms;
	} char_word_t;

	typedef struct packed {
		logic [18:0] time_seconds;
		logic [6:0]  lat_degrees;
		logic [6:0]  lat_minutes;
		logic [6:0]  lon_degrees;
		logic [6:0]  lon_minutes;
		logic        coord_valid;
		logic [31:0] fix_stamp_ms;
	} fix_word_t;

	// digits as captured by the front end, lon_digits holds longitude positions 1..4
	typedef struct packed {
		digit_t [5:0] time_digits;
		digit_t [3:0] lat_digits;
		digit_t [3:0] lon_digits;
		logic         coord_valid;
		logic [31:0]  fix_stamp_ms;
	} snap_t;

	function automatic logic [7:0] header_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = CH_G;
			3'd1:    ch = CH_P;
			3'd2:    ch = CH_G;
			3'd3:    ch = CH_G;
			3'd4:    ch = CH_A;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic digit_t digit_value(input logic [7:0] c);
		digit_t d;
		if (c inside {[8'h30:8'h39]}) d = c[3:0];
		else d = 4'd0;
		return d;
	endfunction

	function automatic digit_t hex_value(input logic [7:0] c);
		digit_t d;
		if (c inside {[8'h30:8'h39]}) d = c[3:0];
		else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) d = 4'(c[3:0] + 4'd9);
		else d = 4'd0;
		return d;
	endfunction

	function automatic logic [6:0] two_digits(input digit_t hi, input digit_t lo);
		return 7'(7'(hi) * 7'd10 + 7'(lo));
	endfunction

endpackage

// ----- hw/rtl/gga_stream_if.sv -----
// ----------------------------------------------------------------------------
// gga_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface gga_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gga_front.sv -----
// ----------------------------------------------------------------------------
// gga_front
// Sentence scanner: header match, checksum, field capture, fix hand-off.
// ----------------------------------------------------------------------------
module gga_front #(
	parameter int TIME_CHARS = 6,
	parameter int LAT_CHARS  = 4,
	parameter int LON_CHARS  = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	gga_stream_if.sink     sentence,
	input  logic           q_full,
	output logic           push,
	output gga_pkg::snap_t push_data
);

	gga_pkg::phase_t phase_q, phase_d;
	logic [7:0] field_q, field_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] rsum_q, rsum_d;
	gga_pkg::digit_t [5:0] time_d_q;
	gga_pkg::digit_t [3:0] lat_d_q;
	gga_pkg::digit_t [3:0] lon_d_q;
	logic [31:0] stamp_q;
	logic        pvalid_q;

	logic [7:0] c;
	logic       accept;
	logic       start;
	logic       store;
	logic       sum_ok;
	logic       hdr_hit;
	logic [7:0] field_inc;
	logic [7:0] pos_inc;
	gga_pkg::digit_t dval;
	gga_pkg::digit_t hval;

	assign c       = sentence.data.char_in;
	assign sentence.ready = !q_full;
	assign accept  = sentence.valid && sentence.ready;
	assign hdr_hit = (pos_q < gga_pkg::HDR_LEN) && (c == gga_pkg::header_char(pos_q[2:0]));
	assign field_inc = (field_q == gga_pkg::SAT_MAX) ? field_q : 8'(field_q + 8'd1);
	assign pos_inc   = (pos_q == gga_pkg::SAT_MAX) ? pos_q : 8'(pos_q + 8'd1);
	assign dval = gga_pkg::digit_value(c);
	assign hval = gga_pkg::hex_value(c);

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			gga_pkg::PH_IDLE: begin
				phase_d = (c == gga_pkg::CH_DOLLAR) ? gga_pkg::PH_HEADER : gga_pkg::PH_IDLE;
			end
			gga_pkg::PH_HEADER: begin
				if (c == gga_pkg::CH_COMMA)
					phase_d = (pos_q == gga_pkg::HDR_LEN) ? gga_pkg::PH_DATA : gga_pkg::PH_IDLE;
				else if (hdr_hit)
					phase_d = gga_pkg::PH_HEADER;
				else
					phase_d = gga_pkg::PH_IDLE;
			end
			gga_pkg::PH_DATA: begin
				phase_d = (c == gga_pkg::CH_STAR) ? gga_pkg::PH_SUM : gga_pkg::PH_DATA;
			end
			gga_pkg::PH_SUM: begin
				phase_d = (pos_q >= gga_pkg::SUM_DIGITS) ? gga_pkg::PH_IDLE : gga_pkg::PH_SUM;
			end
			default: phase_d = gga_pkg::PH_IDLE;
		endcase
	end

	// outputs and datapath updates
	always_comb begin
		field_d = field_q;
		pos_d   = pos_q;
		xor_d   = xor_q;
		rsum_d  = rsum_q;
		start   = 1'b0;
		store   = 1'b0;
		sum_ok  = 1'b0;
		case (phase_q)
			gga_pkg::PH_IDLE: begin
				if (c == gga_pkg::CH_DOLLAR) begin
					start   = 1'b1;
					field_d = 8'd0;
					pos_d   = 8'd0;
					xor_d   = 8'd0;
					rsum_d  = 8'd0;
				end
			end
			gga_pkg::PH_HEADER: begin
				xor_d = xor_q ^ c;
				if (c == gga_pkg::CH_COMMA) begin
					pos_d   = 8'd0;
					field_d = (pos_q == gga_pkg::HDR_LEN) ? 8'd1 : 8'd0;
				end else if (hdr_hit) begin
					pos_d = 8'(pos_q + 8'd1);
				end else begin
					pos_d   = 8'd0;
					field_d = 8'd0;
				end
			end
			gga_pkg::PH_DATA: begin
				if (c == gga_pkg::CH_COMMA) begin
					field_d = field_inc;
					pos_d   = 8'd0;
					xor_d   = xor_q ^ c;
				end else if (c == gga_pkg::CH_STAR) begin
					field_d = field_inc;
					pos_d   = 8'd0;
				end else begin
					store = 1'b1;
					pos_d = pos_inc;
					xor_d = xor_q ^ c;
				end
			end
			gga_pkg::PH_SUM: begin
				if (pos_q >= gga_pkg::SUM_DIGITS) begin
					sum_ok  = (rsum_q == xor_q);
					pos_d   = 8'd0;
					field_d = 8'd0;
				end else begin
					rsum_d = (pos_q == 8'd0) ? {hval, 4'b0000} : 8'(rsum_q + {4'b0000, hval});
					pos_d  = 8'(pos_q + 8'd1);
				end
			end
			default: ;
		endcase
	end

	assign push = accept && sum_ok;
	assign push_data.time_digits  = time_d_q;
	assign push_data.lat_digits   = lat_d_q;
	assign push_data.lon_digits   = lon_d_q;
	assign push_data.coord_valid  = pvalid_q;
	assign push_data.fix_stamp_ms = stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gga_pkg::PH_IDLE;
			field_q <= 8'd0;
			pos_q   <= 8'd0;
			xor_q   <= 8'd0;
			rsum_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			field_q <= field_d;
			pos_q   <= pos_d;
			xor_q   <= xor_d;
			rsum_q  <= rsum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_d_q <= '0;
			lat_d_q  <= '0;
			lon_d_q  <= '0;
			stamp_q  <= 32'd0;
			pvalid_q <= 1'b0;
		end else if (accept) begin
			if (start) begin
				stamp_q  <= 32'd0;
				pvalid_q <= 1'b0;
			end
			if (store) begin
				for (int i = 0; i < 6; i++) begin
					if (field_q == 8'd1 && pos_q == 8'(i)) time_d_q[i] <= dval;
				end
				for (int i = 0; i < 4; i++) begin
					if (field_q == 8'd2 && pos_q == 8'(i) && i < LAT_CHARS) lat_d_q[i] <= dval;
					if (field_q == 8'd4 && pos_q == 8'(i + 1)) lon_d_q[i] <= dval;
				end
				if (field_q == 8'd1 && pos_q == 8'(TIME_CHARS - 1)) stamp_q <= sentence.data.now_ms;
				if (field_q == 8'd4 && pos_q == 8'(LON_CHARS - 1)) pvalid_q <= 1'b1;
			end
		end
	end

	a_dollar_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == gga_pkg::PH_IDLE && c == gga_pkg::CH_DOLLAR
		|=> phase_q == gga_pkg::PH_HEADER && !pvalid_q && stamp_q == 32'd0)
		else $error("start of sentence did not clear pending fix");

	a_push_phase: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> phase_q == gga_pkg::PH_SUM && pos_q >= gga_pkg::SUM_DIGITS)
		else $error("fix pushed outside checksum end");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> phase_q == gga_pkg::PH_IDLE && pos_q == 8'd0 && field_q == 8'd0)
		else $error("parser not idle after fix");

endmodule

// ----- hw/rtl/gga_fifo.sv -----
// ----------------------------------------------------------------------------
// gga_fifo
// Short queue of captured fixes between the scanner and the converter.
// ----------------------------------------------------------------------------
module gga_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  gga_pkg::snap_t wr_data,
	output logic           full,
	output logic           rd_valid,
	input  logic           rd_en,
	output gga_pkg::snap_t rd_data
);

	localparam int DEPTH = gga_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gga_pkg::snap_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (do_wr && !do_rd) count_q <= CNT_W'(count_q + 1'b1);
			else if (do_rd && !do_wr) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("write into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("read from empty queue");

endmodule

// ----- hw/rtl/gga_back.sv -----
// ----------------------------------------------------------------------------
// gga_back
// Converts captured digits into seconds of day and coordinate values.
// ----------------------------------------------------------------------------
module gga_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  gga_pkg::snap_t q_data,
	output logic           pop,
	gga_stream_if.source   fix
);

	logic        v_s1;
	logic [6:0]  hh_s1;
	logic [6:0]  mm_s1;
	logic [6:0]  ss_s1;
	logic [6:0]  latd_s1;
	logic [6:0]  latm_s1;
	logic [6:0]  lond_s1;
	logic [6:0]  lonm_s1;
	logic        cv_s1;
	logic [31:0] stamp_s1;

	logic               v_s2;
	gga_pkg::fix_word_t word_s2;

	logic adv1;
	logic adv2;

	assign adv2 = !v_s2 || fix.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = q_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hh_s1    <= gga_pkg::two_digits(q_data.time_digits[0], q_data.time_digits[1]);
			mm_s1    <= gga_pkg::two_digits(q_data.time_digits[2], q_data.time_digits[3]);
			ss_s1    <= gga_pkg::two_digits(q_data.time_digits[4], q_data.time_digits[5]);
			latd_s1  <= gga_pkg::two_digits(q_data.lat_digits[0], q_data.lat_digits[1]);
			latm_s1  <= gga_pkg::two_digits(q_data.lat_digits[2], q_data.lat_digits[3]);
			lond_s1  <= gga_pkg::two_digits(q_data.lon_digits[0], q_data.lon_digits[1]);
			lonm_s1  <= gga_pkg::two_digits(q_data.lon_digits[2], q_data.lon_digits[3]);
			cv_s1    <= q_data.coord_valid;
			stamp_s1 <= q_data.fix_stamp_ms;
		end
		if (adv2 && v_s1) begin
			word_s2.time_seconds <= 19'(19'(hh_s1) * gga_pkg::SEC_PER_HOUR
				+ 19'(mm_s1) * gga_pkg::SEC_PER_MIN + 19'(ss_s1));
			word_s2.lat_degrees  <= latd_s1;
			word_s2.lat_minutes  <= latm_s1;
			word_s2.lon_degrees  <= lond_s1;
			word_s2.lon_minutes  <= lonm_s1;
			word_s2.coord_valid  <= cv_s1;
			word_s2.fix_stamp_ms <= stamp_s1;
		end
	end

	assign fix.valid = v_s2;
	assign fix.data  = word_s2;

endmodule

// ----- hw/rtl/gga_sentence_time_position_parser.sv -----
// ----------------------------------------------------------------------------
// gga_sentence_time_position_parser
// GGA sentence parser producing time of day, position and capture stamp.
//
// Channels: sentence carries one character word per cycle (char_in, now_ms);
// fix carries one word per sentence whose checksum matched, on the character
// that follows the two checksum digits. Both use valid/ready.
// Throughput: one character per cycle; sentence.ready drops only while the
// two-entry fix queue is full.
// Path: a fix word reaches fix through the queue, the digit stage and the output
// register, in that order, once the character that completes it is taken.
// Stall: while fix.ready is low the output word holds, the converter and the
// queue fill, and the scanner keeps taking characters until the queue holds
// two further fixes.
// Reset: parser returns to waiting for a dollar, stored digits read as zero,
// pending stamp and coordinate flag clear, queue and output empty.
// ----------------------------------------------------------------------------
module gga_sentence_time_position_parser #(
	parameter int TIME_CHARS = 6,
	parameter int LAT_CHARS  = 4,
	parameter int LON_CHARS  = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	gga_stream_if.sink   sentence,
	gga_stream_if.source fix
);

	logic           q_full;
	logic           push;
	gga_pkg::snap_t push_data;
	logic           q_valid;
	logic           pop;
	gga_pkg::snap_t q_data;

	gga_front #(
		.TIME_CHARS (TIME_CHARS),
		.LAT_CHARS  (LAT_CHARS),
		.LON_CHARS  (LON_CHARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sentence  (sentence),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	gga_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (push_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_en    (pop),
		.rd_data  (q_data)
	);

	gga_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.fix     (fix)
	);

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GGA sentence time and position parser.
// Drives a table of directed sentences, then random sentences, broken headers
// and noise on the sentence channel. Both channels get random gaps, one long
// hold on the fix channel, and a quiet tail with no gaps. Every fix word is
// predicted from the characters taken (or given by a typed table row) and compared field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int TIME_LEN = 6;
	localparam int LAT_LEN = 4;
	localparam int LON_LEN = 5;
	localparam int ITEM_GOAL = 1600;
	localparam int PRESS_FROM = 700;
	localparam int PRESS_LINES = 30;
	localparam int QUIET_FROM = 1300;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX = 10;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum int {
		SUM_UPPER,
		SUM_LOWER,
		SUM_BAD,
		SUM_JUNK,
		SUM_RAW
	} sum_mode_t;

	typedef struct {
		string      text;
		sum_mode_t  mode;
		logic [7:0] trailer;
		logic [31:0] stamp;
		bit         typed;
		bit         typed_fix;
		gga_pkg::fix_word_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gga_stream_if #(.T(gga_pkg::char_word_t)) char_bus ();
	gga_stream_if #(.T(gga_pkg::fix_word_t)) fix_bus ();

	gga_sentence_time_position_parser #(
		.TIME_CHARS(TIME_LEN),
		.LAT_CHARS(LAT_LEN),
		.LON_CHARS(LON_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(char_bus),
		.fix(fix_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser image
	gga_pkg::phase_t ph;
	logic [7:0] fld;
	logic [7:0] pos;
	logic [7:0] xsum;
	logic [7:0] rsum;
	logic [7:0] time_ch [TIME_LEN];
	logic [7:0] lat_ch [LAT_LEN];
	logic [7:0] lon_ch [LON_LEN];
	logic [31:0] stamp_hold;
	logic       coord_hold;

	logic [7:0] hdr_text [5] = '{gga_pkg::CH_G, gga_pkg::CH_P, gga_pkg::CH_G, gga_pkg::CH_G,
		gga_pkg::CH_A};

	gga_pkg::fix_word_t fix_expect_q [$];
	int chars_sent = 0;
	int mism_cnt = 0;
	int cycle_cnt = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_req = 1'b0;

	dir_row_t dir_rows [17] = '{
		'{"GPGGA,", SUM_UPPER, CH_LF, 32'h1234_5678, 1'b1, 1'b1, '0},
		'{"GPGGA,999999,9999,N,99999,E", SUM_UPPER, CH_CR, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{time_seconds: 19'd362439, lat_degrees: 7'd99, lat_minutes: 7'd99,
			lon_degrees: 7'd99, lon_minutes: 7'd99, coord_valid: 1'b1,
			fix_stamp_ms: 32'hFFFF_FFFF}},
		'{"GPGGA,000000,0000,S,00000,W", SUM_LOWER, CH_LF, 32'h0, 1'b1, 1'b1,
			'{time_seconds: 19'd0, lat_degrees: 7'd0, lat_minutes: 7'd0,
			lon_degrees: 7'd0, lon_minutes: 7'd0, coord_valid: 1'b1,
			fix_stamp_ms: 32'h0}},
		'{"GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", SUM_UPPER,
			CH_CR, 32'h8000_0001, 1'b0, 1'b0, '0},
		'{"GPGGA,1a2b3c,x1y2,N,z9a8b,E", SUM_LOWER, CH_CR, 32'h5555_AAAA, 1'b0, 1'b0, '0},
		'{"GPGGA,12,3,N,7,E", SUM_UPPER, CH_CR, 32'h0F0F_F0F0, 1'b0, 1'b0, '0},
		'{"GPGGA,235959,5959,N,17959,W", SUM_BAD, CH_CR, 32'h0000_FFFF, 1'b1, 1'b0, '0},
		'{"$GPGSA,A,3*7A\n", SUM_RAW, CH_CR, 32'h1111_1111, 1'b0, 1'b0, '0},
		'{"$GPGG,1234*00\n", SUM_RAW, CH_CR, 32'h2222_2222, 1'b0, 1'b0, '0},
		'{"$GPGGAA,1234*00\n", SUM_RAW, CH_CR, 32'h3333_3333, 1'b0, 1'b0, '0},
		'{"$GP$GPGGA,*7A\n", SUM_RAW, CH_CR, 32'h4444_4444, 1'b0, 1'b0, '0},
		'{"GPGGA,12$519,48$7,N", SUM_UPPER, gga_pkg::CH_DOLLAR, 32'h6666_6666, 1'b0, 1'b0, '0},
		'{"GPGGA,*7A\n", SUM_RAW, CH_CR, 32'h7777_7777, 1'b0, 1'b0, '0},
		'{"$GPGGA,*$A\n", SUM_RAW, CH_CR, 32'h8888_8888, 1'b0, 1'b0, '0},
		'{"$GPGGA,\n*7q\n", SUM_RAW, CH_CR, 32'h9999_9999, 1'b0, 1'b0, '0},
		'{"GPGGA,1234567890,123456789,N,1234567890123,E,,,,,", SUM_UPPER, CH_CR,
			32'hCAFE_0001, 1'b0, 1'b0, '0},
		'{"GPGGA,000001,0100,N,10100,E", SUM_JUNK, CH_CR, 32'h0BAD_0001, 1'b0, 1'b0, '0}
	};

	function automatic int dec_val(input logic [7:0] c);
		return (c >= "0" && c <= "9") ? int'(c - "0") : 0;
	endfunction

	function automatic int pair_val(input logic [7:0] hi, input logic [7:0] lo);
		return dec_val(hi) * 10 + dec_val(lo);
	endfunction

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 8'd10;
		if (c >= "a" && c <= "f") return c - "a" + 8'd10;
		return 8'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) return 8'("0") + 8'(n);
		return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	task automatic enter_idle();
		ph = gga_pkg::PH_IDLE;
		fld = 8'd0;
		pos = 8'd0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic [31:0] now, output bit got,
			output gga_pkg::fix_word_t fw);
		got = 1'b0;
		fw = '0;
		case (ph)
			gga_pkg::PH_HEADER: begin
				if (c == gga_pkg::CH_COMMA) begin
					if (pos == gga_pkg::HDR_LEN) begin
						fld = 8'd1;
						pos = 8'd0;
						ph = gga_pkg::PH_DATA;
					end else begin
						enter_idle();
					end
				end else if (pos < gga_pkg::HDR_LEN && c == hdr_text[pos]) begin
					pos++;
				end else begin
					enter_idle();
				end
				xsum ^= c;
			end
			gga_pkg::PH_DATA: begin
				if (c == gga_pkg::CH_COMMA || c == gga_pkg::CH_STAR) begin
					if (fld != gga_pkg::SAT_MAX) fld++;
					pos = 8'd0;
					if (c == gga_pkg::CH_STAR) ph = gga_pkg::PH_SUM;
					else xsum ^= c;
				end else begin
					if (fld == 8'd1 && pos < TIME_LEN) begin
						time_ch[pos] = c;
						if (pos == TIME_LEN - 1) stamp_hold = now;
					end else if (fld == 8'd2 && pos < LAT_LEN) begin
						lat_ch[pos] = c;
					end else if (fld == 8'd4 && pos < LON_LEN) begin
						lon_ch[pos] = c;
						if (pos == LON_LEN - 1) coord_hold = 1'b1;
					end
					if (pos != gga_pkg::SAT_MAX) pos++;
					xsum ^= c;
				end
			end
			gga_pkg::PH_SUM: begin
				if (pos >= gga_pkg::SUM_DIGITS) begin
					if (rsum == xsum) begin
						got = 1'b1;
						fw.time_seconds = 19'(pair_val(time_ch[0], time_ch[1])
							* int'(gga_pkg::SEC_PER_HOUR)
							+ pair_val(time_ch[2], time_ch[3]) * int'(gga_pkg::SEC_PER_MIN)
							+ pair_val(time_ch[4], time_ch[5]));
						fw.lat_degrees = 7'(pair_val(lat_ch[0], lat_ch[1]));
						fw.lat_minutes = 7'(pair_val(lat_ch[2], lat_ch[3]));
						fw.lon_degrees = 7'(pair_val(lon_ch[1], lon_ch[2]));
						fw.lon_minutes = 7'(pair_val(lon_ch[3], lon_ch[4]));
						fw.coord_valid = coord_hold;
						fw.fix_stamp_ms = stamp_hold;
					end
					enter_idle();
				end else begin
					if (pos == 8'd0) rsum = hex_val(c) << 4;
					else rsum = rsum + hex_val(c);
					pos++;
				end
			end
			default: begin
				if (c == gga_pkg::CH_DOLLAR) begin
					fld = 8'd0;
					pos = 8'd0;
					xsum = 8'd0;
					rsum = 8'd0;
					coord_hold = 1'b0;
					stamp_hold = 32'd0;
					ph = gga_pkg::PH_HEADER;
				end else begin
					ph = gga_pkg::PH_IDLE;
				end
			end
		endcase
	endtask

	// typed rows override the prediction on their last word
	task automatic put_char(input logic [7:0] c, input logic [31:0] now, input bit typed,
			input bit typed_fix, input gga_pkg::fix_word_t want);
		bit got;
		gga_pkg::fix_word_t fw;
		if (send_idle_on && $urandom_range(0, 7) == 0) begin
			char_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.data <= {c, now};
		@(posedge clk);
		while (!char_bus.ready) @(posedge clk);
		parse_char(c, now, got, fw);
		if (typed) begin
			got = typed_fix;
			fw = want;
		end
		if (got) fix_expect_q.push_back(fw);
		chars_sent++;
	endtask

	task automatic emit_line(input byte unsigned body [$], input sum_mode_t mode,
			input logic [7:0] trailer, input bit fixed_now, input logic [31:0] now,
			input bit typed, input bit typed_fix, input gga_pkg::fix_word_t want);
		byte unsigned line_q [$];
		logic [7:0] sum;
		bit lower;
		sum = 8'd0;
		lower = (mode == SUM_LOWER) || (mode != SUM_UPPER && $urandom_range(0, 1) == 1);
		if (mode == SUM_RAW) begin
			line_q = body;
		end else begin
			foreach (body[i]) sum ^= body[i];
			if (mode == SUM_BAD) sum ^= 8'(1 << $urandom_range(0, 7));
			line_q.push_back(gga_pkg::CH_DOLLAR);
			foreach (body[i]) line_q.push_back(body[i]);
			line_q.push_back(gga_pkg::CH_STAR);
			if (mode == SUM_JUNK) begin
				line_q.push_back(8'($urandom_range(0, 255)));
				line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				line_q.push_back(hex_char(sum[7:4], lower));
				line_q.push_back(hex_char(sum[3:0], lower));
			end
			line_q.push_back(trailer);
		end
		foreach (line_q[i])
			put_char(line_q[i], fixed_now ? now : $urandom(), typed && i == line_q.size() - 1,
				typed_fix, want);
	endtask

	task automatic add_chars(ref byte unsigned q [$], input int n);
		logic [7:0] c;
		repeat (n) begin
			if ($urandom_range(0, 9) != 0) begin
				c = 8'("0") + 8'($urandom_range(0, 9));
			end else begin
				do c = 8'($urandom_range(0, 255));
				while (c == gga_pkg::CH_COMMA || c == gga_pkg::CH_STAR);
			end
			q.push_back(c);
		end
	endtask

	task automatic add_header(ref byte unsigned q [$]);
		foreach (hdr_text[i]) q.push_back(hdr_text[i]);
		q.push_back(gga_pkg::CH_COMMA);
	endtask

	task automatic send_long(input bit many_commas);
		byte unsigned body [$];
		add_header(body);
		if (many_commas) begin
			add_chars(body, TIME_LEN);
			repeat ($urandom_range(256, 280)) body.push_back(gga_pkg::CH_COMMA);
			add_chars(body, 3);
		end else begin
			add_chars(body, $urandom_range(256, 300));
		end
		emit_line(body, $urandom_range(0, 1) ? SUM_LOWER : SUM_UPPER, CH_CR, 1'b0, 32'd0,
			1'b0, 1'b0, '0);
	endtask

	task automatic send_random(input bit short_only);
		byte unsigned body [$];
		int kind;
		int at;
		sum_mode_t mode;
		logic [7:0] trailer;
		kind = short_only ? 0 : $urandom_range(0, 99);
		if (kind >= 92) begin
			repeat ($urandom_range(1, 24)) body.push_back(8'($urandom_range(0, 255)));
			emit_line(body, SUM_RAW, CH_CR, 1'b0, 32'd0, 1'b0, 1'b0, '0);
		end else if (kind == 91) begin
			send_long($urandom_range(0, 1));
		end else begin
			add_header(body);
			// broken headers
			if (kind >= 75 && kind < 85) begin
				at = $urandom_range(0, body.size() - 1);
				case ($urandom_range(0, 3))
					0: body[at] = 8'($urandom_range(0, 255));
					1: body.delete(at);
					2: body.insert(at, 8'($urandom_range(0, 255)));
					default: body.insert(at, gga_pkg::CH_DOLLAR);
				endcase
			end
			add_chars(body, $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : TIME_LEN);
			if (!short_only) begin
				body.push_back(gga_pkg::CH_COMMA);
				add_chars(body, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : LAT_LEN);
				if ($urandom_range(0, 1)) begin
					body.push_back(".");
					add_chars(body, $urandom_range(0, 4));
				end
				body.push_back(gga_pkg::CH_COMMA);
				if ($urandom_range(0, 7) != 0) body.push_back($urandom_range(0, 1) ? "N" : "S");
				body.push_back(gga_pkg::CH_COMMA);
				add_chars(body, $urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : LON_LEN);
				if ($urandom_range(0, 1)) begin
					body.push_back(".");
					add_chars(body, $urandom_range(0, 4));
				end
				body.push_back(gga_pkg::CH_COMMA);
				if ($urandom_range(0, 7) != 0) body.push_back($urandom_range(0, 1) ? "E" : "W");
				repeat ($urandom_range(0, 8)) begin
					body.push_back(gga_pkg::CH_COMMA);
					add_chars(body, $urandom_range(0, 4));
				end
			end
			if (kind >= 70 && kind < 75) mode = SUM_BAD;
			else if (kind >= 65 && kind < 70) mode = SUM_JUNK;
			else mode = $urandom_range(0, 1) ? SUM_LOWER : SUM_UPPER;
			case ($urandom_range(0, 9))
				7: trailer = CH_LF;
				8: trailer = gga_pkg::CH_DOLLAR;
				9: trailer = 8'($urandom_range(0, 255));
				default: trailer = CH_CR;
			endcase
			emit_line(body, mode, trailer, 1'b0, 32'd0, 1'b0, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mism_cnt++;
			if (mism_cnt <= REPORT_MAX)
				$display("tb: %s mismatch, expected %0d got %0d", name, want, got);
		end
	endtask

	initial begin : fix_side
		int burst_left;
		int hold_left;
		bit hold_done;
		gga_pkg::fix_word_t want;
		gga_pkg::fix_word_t got;
		burst_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		fix_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (fix_bus.valid && fix_bus.ready) begin
				got = fix_bus.data;
				if (fix_expect_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= REPORT_MAX)
						$display("tb: unexpected fix word, time %0d stamp %0d",
							got.time_seconds, got.fix_stamp_ms);
				end else begin
					want = fix_expect_q.pop_front();
					check_field("time_seconds", 32'(want.time_seconds), 32'(got.time_seconds));
					check_field("lat_degrees", 32'(want.lat_degrees), 32'(got.lat_degrees));
					check_field("lat_minutes", 32'(want.lat_minutes), 32'(got.lat_minutes));
					check_field("lon_degrees", 32'(want.lon_degrees), 32'(got.lon_degrees));
					check_field("lon_minutes", 32'(want.lon_minutes), 32'(got.lon_minutes));
					check_field("coord_valid", 32'(want.coord_valid), 32'(got.coord_valid));
					check_field("fix_stamp_ms", want.fix_stamp_ms, got.fix_stamp_ms);
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) hold_left--;
			else if (burst_left > 0) burst_left--;
			else if (recv_idle_on && $urandom_range(0, 5) == 0)
				burst_left = $urandom_range(1, 11);
			fix_bus.ready <= arst_n && hold_left == 0 && burst_left == 0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin : char_side
		byte unsigned body [$];
		char_bus.valid = 1'b0;
		char_bus.data = '0;
		enter_idle();
		xsum = 8'd0;
		rsum = 8'd0;
		foreach (time_ch[i]) time_ch[i] = "0";
		foreach (lat_ch[i]) lat_ch[i] = "0";
		foreach (lon_ch[i]) lon_ch[i] = "0";
		stamp_hold = 32'd0;
		coord_hold = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			body.delete();
			for (int k = 0; k < dir_rows[r].text.len(); k++) body.push_back(dir_rows[r].text[k]);
			emit_line(body, dir_rows[r].mode, dir_rows[r].trailer, 1'b1, dir_rows[r].stamp,
				dir_rows[r].typed, dir_rows[r].typed_fix, dir_rows[r].want);
		end
		send_long(1'b0);
		send_long(1'b1);

		while (chars_sent < ITEM_GOAL) begin
			if (!hold_req && chars_sent >= PRESS_FROM) begin
				// drain, then keep offering words into a held fix channel
				char_bus.valid <= 1'b0;
				do @(posedge clk);
				while (fix_expect_q.size() != 0);
				send_idle_on = 1'b0;
				hold_req = 1'b1;
				repeat (PRESS_LINES) send_random(1'b1);
				send_idle_on = 1'b1;
			end
			if (chars_sent >= QUIET_FROM) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			send_random(1'b0);
		end

		char_bus.valid <= 1'b0;
		while (fix_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mism_cnt == 0 && fix_expect_q.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
